// File: src/gpbm_pkg.sv
// shared widths, constants and the queued item type for the peak bar meter
package gpbm_pkg;

  localparam int COLUMN_W    = 5;
  localparam int BIN_W       = 8;
  localparam int FT_W        = 16;
  localparam int GRAV_W      = 10;
  localparam int ROW_W       = 4;
  localparam int HEIGHT_W    = 16;
  localparam int SPEED_W     = 18;
  localparam int COLUMNS_DEF = 32;
  localparam int ROWS_DEF    = 16;

  localparam logic [GRAV_W-1:0] GRAV_RESET = 10'd120;
  localparam logic [BIN_W-1:0]  LEVEL_MAX  = 8'd255;

  typedef struct packed {
    logic [COLUMN_W-1:0] col;
    logic [BIN_W-1:0]    target;
    logic [FT_W-1:0]     ft;
    logic                oor;
  } q_item_t;

endpackage

// File: src/gpbm_front.sv
// input side: accepts items, derives the target level and range flag, two-entry queue
module gpbm_front #(
  parameter int COLUMNS = gpbm_pkg::COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gpbm_pkg::COLUMN_W-1:0] in_column,
  input  logic [gpbm_pkg::BIN_W-1:0]    in_bin_level,
  input  logic [gpbm_pkg::FT_W-1:0]     in_frame_time,
  output logic                          q_valid,
  output gpbm_pkg::q_item_t             q_item,
  input  logic                          q_pop
);
  import gpbm_pkg::*;

  q_item_t     q_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        push;
  logic [BIN_W:0] dbl;
  q_item_t     new_item;

  // doubled level clamped to full scale
  always_comb begin
    dbl             = {in_bin_level, 1'b0};
    new_item.col    = in_column;
    new_item.target = dbl[BIN_W] ? LEVEL_MAX : dbl[BIN_W-1:0];
    new_item.ft     = in_frame_time;
    new_item.oor    = (32'(in_column) >= COLUMNS);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// File: src/gpbm_back.sv
// execution side: column store, gravity and height arithmetic, result register
module gpbm_back #(
  parameter int COLUMNS = gpbm_pkg::COLUMNS_DEF,
  parameter int ROWS    = gpbm_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gpbm_pkg::GRAV_W-1:0]   gravity,
  input  logic                          q_valid,
  input  gpbm_pkg::q_item_t             q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gpbm_pkg::COLUMN_W-1:0] out_column_out,
  output logic [gpbm_pkg::ROW_W-1:0]    out_top_row,
  output logic [gpbm_pkg::HEIGHT_W-1:0] out_bar_level
);
  import gpbm_pkg::*;

  localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int EXT_W = (IDX_W > COLUMN_W) ? IDX_W : COLUMN_W;
  localparam int PROD1_W = GRAV_W + FT_W;
  localparam int PROD2_W = SPEED_W + FT_W;
  localparam int DIFF_W  = SPEED_W + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SPD  = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [SPEED_W-1:0] SPD_MIN  = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam logic [DIFF_W-1:0]  DIFF_MIN = {2'b11, SPD_MIN};
  localparam logic [8:0]         ROW_CAP  = 9'(ROWS - 1);

  logic [HEIGHT_W-1:0] bar_mem [COLUMNS];
  logic [SPEED_W-1:0]  spd_mem [COLUMNS];
  logic [COLUMNS-1:0]  vld_r;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  q_item_t             item_r;
  logic [HEIGHT_W-1:0] h_rd_r;
  logic [SPEED_W-1:0]  sp_rd_r;
  logic                v_rd_r;
  logic                byp_r;
  logic [HEIGHT_W-1:0] byp_h_r;
  logic [SPEED_W-1:0]  byp_sp_r;
  logic [HEIGHT_W-1:0] h_r;
  logic [SPEED_W-1:0]  sp_r;
  logic [PROD1_W-1:0]  dv_r;
  logic [SPEED_W-1:0]  sp_sat_r;
  logic [SPEED_W-1:0]  mag_r;
  logic [SPEED_W-1:0]  dh_r;
  logic                out_valid_r;
  logic [COLUMN_W-1:0] out_col_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [HEIGHT_W-1:0] out_lvl_r;

  logic [EXT_W-1:0]    rd_ext;
  logic [EXT_W-1:0]    wr_ext;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic                done_go;
  logic                mem_we;
  logic [HEIGHT_W-1:0] h_cur;
  logic [SPEED_W-1:0]  sp_cur;
  logic [DIFF_W-1:0]   diff;
  logic [SPEED_W-1:0]  sp_sat;
  logic [SPEED_W-1:0]  mag;
  logic [PROD2_W-1:0]  prod2;
  logic [HEIGHT_W-1:0] target_h;
  logic [HEIGHT_W+2:0] nh;
  logic [HEIGHT_W-1:0] h_fin;
  logic [SPEED_W-1:0]  sp_fin;
  logic [8:0]          row_raw;
  logic [8:0]          row_cap;
  logic [HEIGHT_W:0]   h_rnd;

  assign rd_ext = EXT_W'(q_item.col);
  assign rd_idx = rd_ext[IDX_W-1:0];
  assign wr_ext = EXT_W'(item_r.col);
  assign wr_idx = wr_ext[IDX_W-1:0];

  assign done_go = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign q_pop   = q_valid && ((state_r == S_IDLE) || done_go);
  assign mem_we  = done_go && !item_r.oor;

  // stored state, a never written column reads as zero
  always_comb begin
    if (byp_r) begin
      h_cur  = byp_h_r;
      sp_cur = byp_sp_r;
    end else if (v_rd_r) begin
      h_cur  = h_rd_r;
      sp_cur = sp_rd_r;
    end else begin
      h_cur  = '0;
      sp_cur = '0;
    end
  end

  // speed minus gravity step, saturated at the most negative speed
  always_comb begin
    diff   = {{2{sp_r[SPEED_W-1]}}, sp_r} - DIFF_W'(dv_r[PROD1_W-1:8]);
    sp_sat = ($signed(diff) < $signed(DIFF_MIN)) ? SPD_MIN : diff[SPEED_W-1:0];
    mag    = sp_sat[SPEED_W-1] ? (~sp_sat + SPEED_W'(1)) : sp_sat;
  end

  assign prod2 = PROD2_W'(mag_r) * PROD2_W'(item_r.ft);

  always_comb begin
    target_h = {item_r.target, 8'h00};
    nh       = (HEIGHT_W+3)'(h_r) + (HEIGHT_W+3)'(dh_r);
    if (target_h > h_r) begin
      h_fin  = target_h;
      sp_fin = '0;
    end else if (sp_sat_r[SPEED_W-1]) begin
      if (dh_r >= SPEED_W'(h_r)) begin
        h_fin  = '0;
        sp_fin = '0;
      end else begin
        h_fin  = h_r - dh_r[HEIGHT_W-1:0];
        sp_fin = sp_sat_r;
      end
    end else begin
      h_fin  = (nh > (HEIGHT_W+3)'({HEIGHT_W{1'b1}})) ? {HEIGHT_W{1'b1}} : nh[HEIGHT_W-1:0];
      sp_fin = (h_fin == '0) ? '0 : sp_sat_r;
    end
    h_rnd   = (HEIGHT_W+1)'(h_fin) + (HEIGHT_W+1)'(128);
    row_raw = h_rnd[HEIGHT_W:8];
    row_cap = (row_raw > ROW_CAP) ? ROW_CAP : row_raw;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_SPD;
      S_SPD:  state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_DONE;
      S_DONE: begin
        if (q_pop) begin
          state_nxt = S_MUL;
        end else if (done_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        // same column straight after its own write takes the fresh values
        byp_r <= mem_we && (rd_idx == wr_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      h_rd_r   <= bar_mem[rd_idx];
      sp_rd_r  <= spd_mem[rd_idx];
      v_rd_r   <= vld_r[rd_idx];
      item_r   <= q_item;
      byp_h_r  <= h_fin;
      byp_sp_r <= sp_fin;
    end
    if (mem_we) begin
      bar_mem[wr_idx] <= h_fin;
      spd_mem[wr_idx] <= sp_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      h_r  <= h_cur;
      sp_r <= sp_cur;
      dv_r <= PROD1_W'(gravity) * PROD1_W'(item_r.ft);
    end
    if (state_r == S_SPD) begin
      sp_sat_r <= sp_sat;
      mag_r    <= mag;
    end
    if (state_r == S_MUL2) begin
      dh_r <= prod2[PROD2_W-1:16];
    end
    if (done_go) begin
      out_col_r <= item_r.col;
      out_row_r <= item_r.oor ? '0 : row_cap[ROW_W-1:0];
      out_lvl_r <= item_r.oor ? '0 : h_fin;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_column_out = out_col_r;
  assign out_top_row    = out_row_r;
  assign out_bar_level  = out_lvl_r;

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result overwritten while the output is stalled");

  a_pop_state: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE || state_r == S_DONE))
    else $error("queue popped in the middle of an item");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (32'(out_col_r) >= COLUMNS)) |-> (out_lvl_r == '0 && out_row_r == '0))
    else $error("out of range column gave a nonzero result");

  a_row_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_row_r) <= ROWS - 1))
    else $error("top row above the last row");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    done_go |=> out_valid_r)
    else $error("finished item did not reach the output register");

endmodule

// File: src/gravity_peak_bar_meter_top.sv
// top level of the gravity peak bar meter: gravity register, front queue and back end
//
//  port group  direction  handshake               payload
//  in_         input      in_valid / in_ready     in_column, in_bin_level, in_frame_time
//  out_        output     out_valid / out_ready   out_column_out, out_top_row, out_bar_level
//  cfg_        input      cfg_wr_en               cfg_wr_data (gravity)
//
// the back end takes one item at a time and steps it through: store read, gravity
// multiply, speed saturate, height multiply, then write and output overlapped with the
// next store read; a stalled output holds it in S_DONE. through an empty queue an item
// passes the queue, S_MUL, S_SPD, S_MUL2, S_DONE and the output register to out_valid.
// reset clears the per-column valid bits directly, no clearing pass; gravity resets to 120.
// a two-item queue keeps in_ready high while the output is stalled until it fills.
module gravity_peak_bar_meter_top #(
  parameter int COLUMNS = gpbm_pkg::COLUMNS_DEF,
  parameter int ROWS    = gpbm_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gpbm_pkg::COLUMN_W-1:0] in_column,
  input  logic [gpbm_pkg::BIN_W-1:0]    in_bin_level,
  input  logic [gpbm_pkg::FT_W-1:0]     in_frame_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gpbm_pkg::COLUMN_W-1:0] out_column_out,
  output logic [gpbm_pkg::ROW_W-1:0]    out_top_row,
  output logic [gpbm_pkg::HEIGHT_W-1:0] out_bar_level,
  input  logic                          cfg_wr_en,
  input  logic [gpbm_pkg::GRAV_W-1:0]   cfg_wr_data
);
  import gpbm_pkg::*;

  logic [GRAV_W-1:0] gravity_r;
  logic              q_valid;
  logic              q_pop;
  q_item_t           q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= GRAV_RESET;
    end else if (cfg_wr_en) begin
      gravity_r <= cfg_wr_data;
    end
  end

  gpbm_front #(
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_column    (in_column),
    .in_bin_level (in_bin_level),
    .in_frame_time(in_frame_time),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  gpbm_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .gravity       (gravity_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_column_out(out_column_out),
    .out_top_row   (out_top_row),
    .out_bar_level (out_bar_level)
  );

endmodule

// File: dv/tb_gravity_peak_bar_meter_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the gravity peak bar meter: directed table, then random frames
module tb_gravity_peak_bar_meter_top;
  import gpbm_pkg::*;

  localparam int NCOL          = COLUMNS_DEF;
  localparam int NROW          = ROWS_DEF;
  localparam int RANDOM_ITEMS  = 650;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam longint SPEED_LO  = -131072;
  localparam longint SPEED_HI  = 131071;
  localparam longint HEIGHT_HI = 65535;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    top_row;
    logic [HEIGHT_W-1:0] level;
  } bar_out_t;

  typedef enum logic {ROW_ITEM, ROW_GRAVITY} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [COLUMN_W-1:0] column;
    logic [BIN_W-1:0]    bin;
    logic [FT_W-1:0]     ft;
    logic [GRAV_W-1:0]   grav;
    logic                known;
    logic [ROW_W-1:0]    top_row;
    logic [HEIGHT_W-1:0] level;
  } dir_row_t;

  localparam int DIR_ROWS = 22;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // zero height at zero dt is cleared again
    '{ROW_ITEM,    5'd0,  8'd0,   16'd0,     10'd0,    1'b1, 4'd0,  16'h0000},
    '{ROW_ITEM,    5'd1,  8'd255, 16'd0,     10'd0,    1'b1, 4'd15, 16'hFF00},
    // doubled level clamps to full scale
    '{ROW_ITEM,    5'd2,  8'd128, 16'd65535, 10'd0,    1'b1, 4'd15, 16'hFF00},
    '{ROW_ITEM,    5'd3,  8'd127, 16'd1,     10'd0,    1'b1, 4'd15, 16'hFE00},
    '{ROW_ITEM,    5'd4,  8'd1,   16'd0,     10'd0,    1'b1, 4'd2,  16'h0200},
    // zero dt holds the bar
    '{ROW_ITEM,    5'd4,  8'd0,   16'd0,     10'd0,    1'b1, 4'd2,  16'h0200},
    '{ROW_ITEM,    5'd4,  8'd0,   16'd65535, 10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_ITEM,    5'd1,  8'd0,   16'd1092,  10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_ITEM,    5'd1,  8'd0,   16'd1092,  10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_ITEM,    5'd1,  8'd0,   16'd65535, 10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_ITEM,    5'd31, 8'd200, 16'd43690, 10'd0,    1'b1, 4'd15, 16'hFF00},
    '{ROW_ITEM,    5'd31, 8'd0,   16'd65535, 10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_GRAVITY, 5'd0,  8'd0,   16'd0,     10'd1023, 1'b0, 4'd0,  16'h0000},
    // fall speed hits its floor in one step
    '{ROW_ITEM,    5'd2,  8'd0,   16'd65535, 10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_ITEM,    5'd3,  8'd0,   16'd256,   10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_ITEM,    5'd3,  8'd0,   16'd256,   10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_GRAVITY, 5'd0,  8'd0,   16'd0,     10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_ITEM,    5'd3,  8'd0,   16'd65535, 10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_ITEM,    5'd5,  8'd64,  16'd0,     10'd0,    1'b1, 4'd15, 16'h8000},
    '{ROW_ITEM,    5'd6,  8'd7,   16'd100,   10'd0,    1'b1, 4'd14, 16'h0E00},
    '{ROW_ITEM,    5'd5,  8'd0,   16'd65535, 10'd0,    1'b0, 4'd0,  16'h0000},
    '{ROW_ITEM,    5'd7,  8'd16,  16'd200,   10'd0,    1'b1, 4'd15, 16'h2000}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [COLUMN_W-1:0] in_column = '0;
  logic [BIN_W-1:0]    in_bin_level = '0;
  logic [FT_W-1:0]     in_frame_time = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COLUMN_W-1:0] out_column_out;
  logic [ROW_W-1:0]    out_top_row;
  logic [HEIGHT_W-1:0] out_bar_level;
  logic                cfg_wr_en = 1'b0;
  logic [GRAV_W-1:0]   cfg_wr_data = '0;

  // predictor state
  logic [HEIGHT_W-1:0] bar_h [NCOL];
  longint              fall_v [NCOL];
  logic [GRAV_W-1:0]   gravity_q;

  bar_out_t bars_due[$];
  int       send_idle_pct = 10;
  int       recv_idle_pct = 71;
  int       errors = 0;
  int       items_sent = 0;
  int       results_seen = 0;
  int       gravity_writes = 0;
  int       stall_cycles = 0;

  gravity_peak_bar_meter_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_column     (in_column),
    .in_bin_level  (in_bin_level),
    .in_frame_time (in_frame_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_column_out(out_column_out),
    .out_top_row   (out_top_row),
    .out_bar_level (out_bar_level),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // one frame step of one column: jump up to the target or fall under gravity
  function automatic bar_out_t advance_bar(logic [COLUMN_W-1:0] col, logic [BIN_W-1:0] bin,
                                           logic [FT_W-1:0] ft);
    bar_out_t res;
    longint   target;
    longint   h;
    longint   sp;
    longint   dh;
    longint   row;
    res.column  = col;
    res.top_row = '0;
    res.level   = '0;
    if (col >= NCOL) return res;
    target = 2 * longint'(bin);
    if (target > longint'(LEVEL_MAX)) target = longint'(LEVEL_MAX);
    target = target << 8;
    h  = longint'(bar_h[col]);
    sp = fall_v[col];
    if (target > h) begin
      h  = target;
      sp = 0;
    end else begin
      sp = sp - ((longint'(gravity_q) * longint'(ft)) >>> 8);
      if (sp < SPEED_LO) sp = SPEED_LO;
      if (sp > SPEED_HI) sp = SPEED_HI;
      // magnitude truncates, so the move rounds toward zero
      dh = (((sp < 0) ? -sp : sp) * longint'(ft)) >>> 16;
      if (sp < 0) begin
        if (dh >= h) begin
          h  = 0;
          sp = 0;
        end else begin
          h = h - dh;
        end
      end else begin
        h = (h + dh > HEIGHT_HI) ? HEIGHT_HI : h + dh;
        if (h == 0) sp = 0;
      end
    end
    bar_h[col]  = h[HEIGHT_W-1:0];
    fall_v[col] = sp;
    row = (h + 128) >>> 8;
    if (row > NROW - 1) row = NROW - 1;
    res.level   = h[HEIGHT_W-1:0];
    res.top_row = row[ROW_W-1:0];
    return res;
  endfunction

  task automatic send_bin(input logic [COLUMN_W-1:0] col, input logic [BIN_W-1:0] bin,
                          input logic [FT_W-1:0] ft, output bar_out_t predicted);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_column     <= col;
    in_bin_level  <= bin;
    in_frame_time <= ft;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_bar(col, bin, ft);
    items_sent++;
  endtask

  // stop sending and wait until every predicted bar has come back
  task automatic drain_bars();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bars_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_gravity(input logic [GRAV_W-1:0] g);
    drain_bars();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    gravity_q = g;
    gravity_writes++;
  endtask

  task automatic check_field(input string what, input logic [HEIGHT_W-1:0] want,
                             input logic [HEIGHT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    bar_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (bars_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual column %0d level %0d",
                 $time, out_column_out, out_bar_level);
        errors++;
      end else begin
        want = bars_due.pop_front();
        check_field("column_out", HEIGHT_W'(want.column), HEIGHT_W'(out_column_out));
        check_field("top_row", HEIGHT_W'(want.top_row), HEIGHT_W'(out_top_row));
        check_field("bar_level", want.level, out_bar_level);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    bar_out_t            want;
    logic [COLUMN_W-1:0] col;
    logic [BIN_W-1:0]    bin;
    logic [FT_W-1:0]     ft;
    logic [GRAV_W-1:0]   grav;
    int                  per_phase;
    int                  r;
    gravity_q = GRAV_RESET;
    for (int c = 0; c < NCOL; c++) begin
      bar_h[c]  = '0;
      fall_v[c] = 0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_GRAVITY) begin
        write_gravity(dir_rows[i].grav);
      end else begin
        send_bin(dir_rows[i].column, dir_rows[i].bin, dir_rows[i].ft, want);
        if (dir_rows[i].known) begin
          want.top_row = dir_rows[i].top_row;
          want.level   = dir_rows[i].level;
        end
        bars_due.push_back(want);
      end
    end

    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       grav = 10'd1023;
        1:       grav = 10'd0;
        3:       grav = 10'd1;
        5:       grav = GRAV_RESET;
        default: grav = GRAV_W'($urandom_range(0, 1023));
      endcase
      write_gravity(grav);
      send_idle_pct = (p < 2) ? 10 : (p < 4) ? 71 : 0;
      recv_idle_pct = (p < 2) ? 71 : (p < 4) ? 10 : 0;
      for (int n = 0; n < per_phase; n++) begin
        // mostly a few columns revisited frame after frame so bars rise and fall
        col = ($urandom_range(0, 99) < 80) ? COLUMN_W'($urandom_range(0, 3))
                                           : COLUMN_W'($urandom_range(0, NCOL - 1));
        r = $urandom_range(0, 99);
        if (r < 65)      bin = BIN_W'($urandom_range(0, 12));
        else if (r < 85) bin = BIN_W'($urandom);
        else             bin = $urandom_range(0, 1) ? LEVEL_MAX : '0;
        r = $urandom_range(0, 99);
        if (r < 15)      ft = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else if (r < 55) ft = FT_W'($urandom_range(0, 4095));
        else             ft = FT_W'($urandom);
        send_bin(col, bin, ft, want);
        bars_due.push_back(want);
        if (n == per_phase / 2) drain_bars();
      end
    end

    drain_bars();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items and %0d results under %0d gravity settings",
             items_sent, results_seen, gravity_writes + 1);
    $display("idle mixes: sender-light, receiver-light and none; %0d mismatches", errors);
    if (errors == 0 && bars_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
src/gpbm_pkg.sv
src/gpbm_front.sv
src/gpbm_back.sv
src/gravity_peak_bar_meter_top.sv
dv/tb_gravity_peak_bar_meter_top.sv
